/* sv/srs_pkg.sv */
// shared constants and types for the stratified roulette selection block
`default_nettype none

package srs_pkg;

    localparam int SCORE_W = 16;
    localparam int RAND_W  = 16;
    localparam int SUM_W   = 24;
    localparam int DRAW_W  = 7;
    localparam int DC_W    = 6;
    localparam int IDX_W   = 8;
    localparam int PROD_W  = SUM_W + DRAW_W;
    localparam int THR_W   = SUM_W + DC_W + RAND_W;
    localparam int LHS_W   = PROD_W + RAND_W;

    localparam logic [DRAW_W-1:0] DEFAULT_DRAWS = 7'd20;
    localparam logic [DRAW_W-1:0] MAX_DRAWS     = 7'd64;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    typedef struct packed {
        logic append;
        logic clear;
        logic rd_en;
    } srs_ctl_t;

endpackage

`default_nettype wire

/* sv/srs_cum_table.sv */
// cumulative fitness table with population count and saturating running total
`default_nettype none

module srs_cum_table #(
    parameter int MAX_POPULATION = 256,
    parameter int ADDR_W         = $clog2(MAX_POPULATION),
    parameter int CNT_W          = $clog2(MAX_POPULATION + 1)
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  srs_pkg::srs_ctl_t            ctl,
    input  wire  [srs_pkg::SCORE_W-1:0]  score,
    input  wire  [ADDR_W-1:0]            rd_addr,
    output logic [srs_pkg::SUM_W-1:0]    rd_data,
    output logic [CNT_W-1:0]             count,
    output logic [srs_pkg::SUM_W-1:0]    total
);
    import srs_pkg::*;

    logic [SUM_W-1:0] mem [MAX_POPULATION];
    logic [SUM_W-1:0] rdata_reg;
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] total_reg;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    logic             full;
    logic             wr_en;

    assign full     = (count_reg == CNT_W'(MAX_POPULATION));
    assign wr_en    = ctl.append && !full;
    assign sum_wide = {1'b0, total_reg} + (SUM_W + 1)'(score);
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= sum_sat;
        end
        if (ctl.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
        end else if (ctl.clear) begin
            count_reg <= '0;
            total_reg <= '0;
        end else if (wr_en) begin
            count_reg <= count_reg + CNT_W'(1);
            total_reg <= sum_sat;
        end
    end

    assign rd_data = rdata_reg;
    assign count   = count_reg;
    assign total   = total_reg;

endmodule

`default_nettype wire

/* sv/stratified_roulette_selection.sv */
// stratified roulette wheel selection: score loading and per-stratum draws
//
// Load words (tuser 0) append a score to the cumulative table. Draw words
// (tuser 1) take a multiply state for the stratum threshold and then scan the
// table one entry per cycle from index 0, one synchronous read per cycle,
// stopping at the first entry above the threshold or after the last loaded
// entry when nothing qualifies; a draw with a zero total skips the scan.
// Input is accepted one word at a time; a finished result waits in the output
// register while the next word is taken, and a draw whose result finds that
// register still full holds the input until it drains. After the last draw of
// a round the population clears.
`default_nettype none

module stratified_roulette_selection #(
    parameter int MAX_POPULATION = 256,
    parameter int SCORE_BITS     = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // score [15:0], random_fraction [31:16]
    input  wire  [31:0]                  s_tdata,
    // mode
    input  wire                          s_tuser,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // selected_index [7:0]
    output logic [7:0]                   m_tdata,
    // found
    output logic                         m_tuser,
    output logic                         m_tlast,
    input  wire                          cfg_we,
    input  wire  [srs_pkg::DRAW_W-1:0]   cfg_wdata
);
    import srs_pkg::*;

    localparam int ADDR_W    = $clog2(MAX_POPULATION);
    localparam int CNT_W     = $clog2(MAX_POPULATION + 1);
    localparam int MASK_BITS = (SCORE_BITS < SCORE_W) ? SCORE_BITS : SCORE_W;
    localparam logic [SCORE_W-1:0] SCORE_MASK = SCORE_W'((64'd1 << MASK_BITS) - 64'd1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_THRESH,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [DRAW_W-1:0] draws_reg;
    logic [DC_W-1:0]   dc_reg;
    logic [RAND_W-1:0] r_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [ADDR_W-1:0] issue_addr_reg;
    logic              issue_on_reg;
    logic              rd_valid_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0]  res_idx_reg;
    logic              res_found_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_found_reg;
    logic              out_last_reg;

    srs_ctl_t          ctl;
    logic [SUM_W-1:0]  rd_data;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  total;
    logic [DRAW_W-1:0] d_eff;
    logic [PROD_W-1:0] prod;
    logic              hit;
    logic              last;
    logic              s_fire;
    logic              out_free;

    srs_cum_table #(
        .MAX_POPULATION (MAX_POPULATION),
        .ADDR_W         (ADDR_W),
        .CNT_W          (CNT_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .score   (s_tdata[SCORE_W-1:0] & SCORE_MASK),
        .rd_addr (issue_addr_reg),
        .rd_data (rd_data),
        .count   (count),
        .total   (total)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        if (draws_reg == '0) begin
            d_eff = DRAW_W'(1);
        end else if (draws_reg > MAX_DRAWS) begin
            d_eff = MAX_DRAWS;
        end else begin
            d_eff = draws_reg;
        end
    end

    assign prod = PROD_W'(rd_data) * PROD_W'(d_eff);
    assign hit  = {prod, {RAND_W{1'b0}}} > LHS_W'(thr_reg);
    assign last = (DRAW_W'(dc_reg) + DRAW_W'(1)) >= d_eff;

    always_comb begin
        ctl.append = s_fire && (s_tuser == MODE_LOAD);
        ctl.clear  = (state_reg == ST_DONE) && out_free && last;
        ctl.rd_en  = (state_reg == ST_SCAN) && issue_on_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draws_reg <= DEFAULT_DRAWS;
        end else if (cfg_we) begin
            draws_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dc_reg        <= '0;
            issue_on_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= ctl.rd_en;
            if (ctl.rd_en) begin
                rd_idx_reg <= issue_addr_reg;
            end
            if (m_tready && (state_reg != ST_DONE)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && (s_tuser == MODE_DRAW)) begin
                        r_reg     <= s_tdata[SCORE_W +: RAND_W];
                        state_reg <= ST_THRESH;
                    end
                end
                ST_THRESH: begin
                    thr_reg <= THR_W'(total) * THR_W'({dc_reg, r_reg});
                    if (total == '0) begin
                        res_idx_reg   <= '0;
                        res_found_reg <= 1'b0;
                        state_reg     <= ST_DONE;
                    end else begin
                        issue_addr_reg <= '0;
                        issue_on_reg   <= 1'b1;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (issue_on_reg) begin
                        issue_addr_reg <= issue_addr_reg + ADDR_W'(1);
                    end
                    if (rd_valid_reg && hit) begin
                        res_idx_reg   <= IDX_W'(rd_idx_reg);
                        res_found_reg <= 1'b1;
                        issue_on_reg  <= 1'b0;
                        state_reg     <= ST_DONE;
                    end else if (rd_valid_reg && (CNT_W'(rd_idx_reg) + CNT_W'(1) == count)) begin
                        res_idx_reg   <= '0;
                        res_found_reg <= 1'b0;
                        issue_on_reg  <= 1'b0;
                        state_reg     <= ST_DONE;
                    end else if (issue_on_reg && (CNT_W'(issue_addr_reg) + CNT_W'(1) == count)) begin
                        issue_on_reg <= 1'b0;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= res_idx_reg;
                        out_found_reg <= res_found_reg;
                        out_last_reg  <= last;
                        dc_reg        <= last ? '0 : dc_reg + DC_W'(1);
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_idx_reg;
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* bench/tb.sv */
// testbench for stratified_roulette_selection with a predictor
`timescale 1ns / 1ps

module tb;
    import srs_pkg::*;

    localparam int POP_MAX  = 256;
    localparam int DRAIN    = 300;
    localparam int HOLD_LEN = 1500;
    localparam int LIMIT    = 1500000;

    typedef struct packed {
        logic        mode;
        logic [15:0] frac;
        logic [15:0] score;
    } ga_word_t;

    typedef struct packed {
        logic [7:0] idx;
        logic       found;
        logic       last;
    } pick_t;

    typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;
    logic              s_tuser   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              cfg_we    = 1'b0;
    logic [DRAW_W-1:0] cfg_wdata = '0;

    ga_word_t    pending[$];
    ga_word_t    held;
    pick_t       picks_due[$];
    flow_t       flow      = FLOW_FREE;
    logic        hold_go   = 1'b0;
    int          hold_left = 0;
    int          mismatches = 0;
    int unsigned cycles    = 0;

    // predictor state
    logic [23:0]       cum_sum [POP_MAX];
    int unsigned       pop_cnt   = 0;
    logic [23:0]       total_fit = '0;
    logic [5:0]        draw_cnt  = '0;
    logic [DRAW_W-1:0] draw_reg  = DEFAULT_DRAWS;

    stratified_roulette_selection i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned strata();
        if (draw_reg == '0) begin
            return 1;
        end
        if (draw_reg > MAX_DRAWS) begin
            return MAX_DRAWS;
        end
        return draw_reg;
    endfunction

    task automatic roulette_step(input ga_word_t w);
        pick_t       p;
        int unsigned d;
        logic [24:0] sum;
        logic [63:0] thr;
        p = '0;
        if (w.mode == MODE_LOAD) begin
            if (pop_cnt < POP_MAX) begin
                sum = {1'b0, total_fit} + 25'(w.score);
                if (sum > 25'hFFFFFF) begin
                    sum = 25'hFFFFFF;
                end
                total_fit = sum[23:0];
                cum_sum[pop_cnt] = sum[23:0];
                pop_cnt++;
            end
        end else begin
            d = strata();
            thr = 64'(total_fit) * ((64'(draw_cnt) << 16) + 64'(w.frac));
            if (total_fit != '0) begin
                for (int j = 0; j < pop_cnt && !p.found; j++) begin
                    if (((64'(cum_sum[j]) * 64'(d)) << 16) > thr) begin
                        p.idx   = 8'(j);
                        p.found = 1'b1;
                    end
                end
            end
            p.last = (int'(draw_cnt) + 1) >= int'(d);
            picks_due.insert(picks_due.size(), p);
            if (p.last) begin
                pop_cnt   = 0;
                total_fit = '0;
                draw_cnt  = '0;
            end else begin
                draw_cnt = draw_cnt + 6'd1;
            end
        end
    endtask

    function automatic bit stall_roll(input bit sender);
        int pct;
        pct = 0;
        case (flow)
            FLOW_SRC_IDLE: begin
                pct = sender ? 83 : 0;
            end
            FLOW_SINK_STALL: begin
                pct = sender ? 0 : 83;
            end
            FLOW_BOTH: begin
                pct = 6;
            end
            default: begin
                pct = 0;
            end
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                roulette_step(held);
            end
            if (!s_tvalid || s_tready) begin
                if (pending.size() > 0 && !stall_roll(1'b1)) begin
                    held = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {held.frac, held.score};
                    s_tuser  <= held.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        pick_t exp_pick;
        if (aresetn && m_tvalid && m_tready) begin
            if (picks_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, got idx %0d found %0b last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                exp_pick = picks_due.pop_front();
                if (m_tdata !== exp_pick.idx || m_tuser !== exp_pick.found ||
                    m_tlast !== exp_pick.last) begin
                    mismatches++;
                    $display("%0t: expected %0d/%0b/%0b (idx/found/last), got %0d/%0b/%0b",
                             $time, exp_pick.idx, exp_pick.found, exp_pick.last,
                             m_tdata, m_tuser, m_tlast);
                end
            end
        end
        m_tready <= (hold_left == 0) && !stall_roll(1'b0);
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (hold_go) begin
            hold_left <= HOLD_LEN;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic put_word(input logic mode, input logic [15:0] score,
                            input logic [15:0] frac);
        ga_word_t w;
        w.mode  = mode;
        w.score = score;
        w.frac  = frac;
        pending.insert(pending.size(), w);
    endtask

    function automatic logic [15:0] rand_score();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_frac();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_rounds(input int n_items);
        int pushed;
        int pop_n;
        int n_draws;
        int pick;
        bit zero_round;
        pushed = 0;
        while (pushed < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                pop_n = 0;
            end else if (pick < 80) begin
                pop_n = $urandom_range(1, 16);
            end else begin
                pop_n = $urandom_range(17, 80);
            end
            zero_round = ($urandom_range(0, 19) == 0);
            for (int i = 0; i < pop_n; i++) begin
                put_word(MODE_LOAD, zero_round ? 16'h0000 : rand_score(), 16'($urandom));
            end
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
                n_draws = strata();
            end else if (pick < 95) begin
                n_draws = $urandom_range(1, strata());
            end else begin
                n_draws = strata() + $urandom_range(1, 3);
            end
            for (int i = 0; i < n_draws; i++) begin
                if ($urandom_range(0, 99) < 8) begin
                    put_word(MODE_LOAD, rand_score(), 16'($urandom));
                    pushed++;
                end
                put_word(MODE_DRAW, 16'($urandom), rand_frac());
            end
            pushed += pop_n + n_draws;
        end
    endtask

    task automatic settle();
        while (pending.size() != 0 || s_tvalid || picks_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic set_draws(input logic [DRAW_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        draw_reg = value;
    endtask

    task automatic run_phase(input logic [DRAW_W-1:0] value, input flow_t mode,
                             input int n_items);
        set_draws(value);
        flow = mode;
        queue_rounds(n_items);
        settle();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset value of the register, empty and zero-total draws
        put_word(MODE_DRAW, 16'h0000, 16'h8000);
        put_word(MODE_LOAD, 16'h0000, 16'h0000);
        put_word(MODE_LOAD, 16'h0000, 16'hFFFF);
        put_word(MODE_DRAW, 16'hFFFF, 16'h0001);
        put_word(MODE_LOAD, 16'hFFFF, 16'h0000);
        put_word(MODE_LOAD, 16'h0001, 16'h0000);
        put_word(MODE_LOAD, 16'h8000, 16'h0000);
        put_word(MODE_DRAW, 16'h0000, 16'h0000);
        put_word(MODE_DRAW, 16'h0000, 16'hFFFF);
        settle();
        // register lowered below the draw count mid-round
        set_draws(7'd3);
        put_word(MODE_DRAW, 16'h0000, 16'h1234);
        settle();
        set_draws(7'd0);
        put_word(MODE_LOAD, 16'h0001, 16'h0000);
        put_word(MODE_DRAW, 16'h0000, 16'hFFFF);
        put_word(MODE_DRAW, 16'h0000, 16'h0000);
        settle();

        run_phase(7'd127, FLOW_FREE, 150);
        run_phase(7'd1, FLOW_SRC_IDLE, 120);
        run_phase(7'd64, FLOW_SINK_STALL, 150);
        run_phase(7'd65, FLOW_BOTH, 150);

        // receiver holds off while the sender keeps offering
        set_draws(7'd5);
        flow = FLOW_FREE;
        queue_rounds(150);
        @(posedge aclk);
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        settle();

        // full population, extra loads are dropped
        set_draws(7'd2);
        for (int i = 0; i < 258; i++) begin
            put_word(MODE_LOAD, ($urandom_range(0, 1) == 0) ? 16'hFFFF : rand_score(),
                     16'($urandom));
        end
        put_word(MODE_DRAW, 16'($urandom), rand_frac());
        put_word(MODE_LOAD, 16'hFFFF, 16'h0000);
        put_word(MODE_DRAW, 16'($urandom), rand_frac());
        settle();

        run_phase(7'($urandom_range(1, 64)), FLOW_SRC_IDLE, 150);
        run_phase(7'd7, FLOW_SINK_STALL, 150);
        run_phase(7'($urandom_range(0, 127)), FLOW_BOTH, 100);

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
